// ===== hdl/pss_pkg.sv =====
// Shared types, constants and codes of the potentiometer sample scaler.
package pss_pkg;

   localparam int SAMPLE_W         = 12;
   localparam int VALUE_W          = 15;
   localparam int HELD_W           = 16;
   localparam int RAW_W            = 12;
   localparam int LIMIT_W          = 14;
   localparam int BAND_W           = 11;
   localparam int COUNT_W          = 13;
   localparam int CSR_IDX_W        = 4;
   localparam int CSR_DATA_W       = 14;
   localparam int PROD_W           = RAW_W + LIMIT_W;
   localparam int REM_W            = RAW_W + 1;
   localparam int DIV_STEPS        = PROD_W;
   localparam int STEP_CNT_W       = $clog2(DIV_STEPS);
   localparam int ADC_BITS_DEFAULT = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE          = 4'd0,
      REG_INVERSE       = 4'd1,
      REG_MAX_RAW       = 4'd2,
      REG_FULL_SCALE    = 4'd3,
      REG_DEAD_BAND     = 4'd4,
      REG_SECTOR_WIDTH  = 4'd5,
      REG_SECTOR_HYST   = 4'd6,
      REG_SECTOR_COUNT  = 4'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      MODE_RAW     = 3'd0,
      MODE_LINEAR  = 3'd1,
      MODE_SYM     = 3'd2,
      MODE_SYM_DB  = 3'd3,
      MODE_CONT    = 3'd4
   } mode_type;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_PRIME  = 1'b1
   } op_type;

   // What the commit step does with the divider result
   typedef enum logic [2:0] {
      KIND_HOLD,
      KIND_ZERO,
      KIND_RAW,
      KIND_LIN,
      KIND_HI,
      KIND_LO,
      KIND_SECTOR,
      KIND_PRIME
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic               inverse;
      logic [RAW_W-1:0]   max_raw;
      logic [LIMIT_W-1:0] full_scale;
      logic [BAND_W-1:0]  dead_band;
      logic [RAW_W-1:0]   sector_width;
      logic [BAND_W-1:0]  sector_hysteresis;
      logic [COUNT_W-1:0] sector_count;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic mul;
      logic step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_status_type;

endpackage

// ===== hdl/pss_if.sv =====
// Handshake channels of the potentiometer sample scaler.
interface pss_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [pss_pkg::SAMPLE_W-1:0]  sample;
   modport source (output valid, output op, output sample, input ready);
   modport sink   (input valid, input op, input sample, output ready);
endinterface

interface pss_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [pss_pkg::VALUE_W-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface pss_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pss_pkg::CSR_IDX_W-1:0]   index;
   logic [pss_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pss_regs.sv =====
// Configuration register file of the potentiometer sample scaler.
module pss_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pss_pkg::CSR_DATA_W-1:0]  csr_data,
   output pss_pkg::cfg_type                cfg
);

   pss_pkg::cfg_type cfg_ff;
   pss_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pss_pkg::REG_MODE:          cfg_in.mode              = csr_data[2:0];
            pss_pkg::REG_INVERSE:       cfg_in.inverse           = csr_data[0];
            pss_pkg::REG_MAX_RAW:       cfg_in.max_raw           = csr_data[pss_pkg::RAW_W-1:0];
            pss_pkg::REG_FULL_SCALE:    cfg_in.full_scale        = csr_data[pss_pkg::LIMIT_W-1:0];
            pss_pkg::REG_DEAD_BAND:     cfg_in.dead_band         = csr_data[pss_pkg::BAND_W-1:0];
            pss_pkg::REG_SECTOR_WIDTH:  cfg_in.sector_width      = csr_data[pss_pkg::RAW_W-1:0];
            pss_pkg::REG_SECTOR_HYST:   cfg_in.sector_hysteresis = csr_data[pss_pkg::BAND_W-1:0];
            pss_pkg::REG_SECTOR_COUNT:  cfg_in.sector_count      = csr_data[pss_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode              <= pss_pkg::MODE_LINEAR;
         cfg_ff.inverse           <= 1'b0;
         cfg_ff.max_raw           <= 12'd1023;
         cfg_ff.full_scale        <= 14'd10000;
         cfg_ff.dead_band         <= '0;
         cfg_ff.sector_width      <= 12'd64;
         cfg_ff.sector_hysteresis <= 11'd8;
         cfg_ff.sector_count      <= 13'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/pss_ctrl.sv =====
// Sequencing state machine of the potentiometer sample scaler.
module pss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  pss_pkg::dp_status_type status,
   output pss_pkg::ctrl_cmd_type  cmd
);

   pss_pkg::state_type                 state_ff, state_in;
   logic [pss_pkg::STEP_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               slot_free;

   assign req_ready = (state_ff == pss_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pss_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         pss_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = pss_pkg::ST_PREP;
            end
         end
         pss_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = pss_pkg::ST_MUL;
         end
         pss_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = status.need_div ? pss_pkg::ST_DIV : pss_pkg::ST_DONE;
         end
         pss_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == pss_pkg::STEP_CNT_W'(pss_pkg::DIV_STEPS - 1)) begin
               state_in = pss_pkg::ST_DONE;
            end
         end
         pss_pkg::ST_DONE: begin
            // hold the result until the output register is free
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = pss_pkg::ST_IDLE;
            end
         end
         default: state_in = pss_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.commit)
      else $error("pending result overwritten");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pss_pkg::ST_DIV) |->
         (cnt_ff < pss_pkg::STEP_CNT_W'(pss_pkg::DIV_STEPS)))
      else $error("divider step count overrun");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == pss_pkg::ST_PREP))
      else $error("accepted request not started");

endmodule

// ===== hdl/pss_dp.sv =====
// Datapath of the potentiometer sample scaler: operand set-up, multiplier,
// shift-subtract divider and result commit.
module pss_dp #(
   parameter int ADC_BITS = pss_pkg::ADC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pss_pkg::cfg_type                    cfg,
   input  pss_pkg::ctrl_cmd_type               cmd,
   output pss_pkg::dp_status_type              status,
   input  logic                                req_op,
   input  logic [pss_pkg::SAMPLE_W-1:0]        req_sample,
   output logic signed [pss_pkg::VALUE_W-1:0]  rsp_value
);

   localparam int SW = pss_pkg::SAMPLE_W;
   localparam int RW = pss_pkg::RAW_W;
   localparam int PW = pss_pkg::PROD_W;
   localparam int MW = pss_pkg::REM_W;
   localparam int HW = pss_pkg::HELD_W;
   localparam logic [SW-1:0] ADC_MASK =
      (ADC_BITS >= SW) ? {SW{1'b1}} : SW'((1 << ADC_BITS) - 1);

   logic                        op_ff;
   logic [RW-1:0]               raw_ff, raw_in, masked;
   pss_pkg::kind_type           kind_ff, kind_in;
   logic [RW-1:0]               mul_a_ff, mul_a_in;
   logic [RW-1:0]               div_d_ff, div_d_in;
   logic [PW-1:0]               quo_ff;
   logic [MW-1:0]               rem_ff;
   logic signed [HW-1:0]        held_ff, held_in;
   logic [RW-1:0]               last_ff, last_in;
   logic signed [pss_pkg::VALUE_W-1:0] value_ff;

   // operand set-up
   logic [RW-1:0]               center;
   logic [pss_pkg::BAND_W-1:0]  band;
   logic [RW:0]                 upper;
   logic signed [RW:0]          lower;
   logic                        above, below;

   // divider step
   logic [MW-1:0]               rem_sh;
   logic                        ge;

   // commit
   logic signed [16:0]          quo_s, lim_s, v_sym, v_cont, delta;
   logic signed [16:0]          half_s, count_s;
   logic signed [HW-1:0]        sym_out;
   logic                        at_edge, overrun;
   logic [RW-1:0]               sector;

   assign masked    = req_sample & ADC_MASK;
   assign raw_in    = (masked > cfg.max_raw) ? cfg.max_raw : masked;
   assign rsp_value = value_ff;

   always_comb begin
      case (kind_ff)
         pss_pkg::KIND_LIN, pss_pkg::KIND_HI, pss_pkg::KIND_LO,
         pss_pkg::KIND_SECTOR, pss_pkg::KIND_PRIME: status.need_div = 1'b1;
         default:                                   status.need_div = 1'b0;
      endcase
   end

   // pick the scaling branch and the multiplier and divisor operands
   always_comb begin
      center   = RW'(({1'b0, cfg.max_raw} + 1'b1) >> 1);
      band     = (cfg.mode == pss_pkg::MODE_SYM_DB) ? cfg.dead_band : '0;
      upper    = {1'b0, center} + (RW+1)'(band);
      lower    = $signed({1'b0, center}) - $signed((RW+1)'(band));
      above    = {1'b0, raw_ff} > upper;
      below    = $signed({1'b0, raw_ff}) < lower;
      kind_in  = pss_pkg::KIND_HOLD;
      mul_a_in = raw_ff;
      div_d_in = cfg.max_raw;
      if (op_ff == pss_pkg::OP_PRIME) begin
         if (cfg.mode == pss_pkg::MODE_CONT && cfg.sector_width != '0) begin
            kind_in  = pss_pkg::KIND_PRIME;
            div_d_in = cfg.sector_width;
         end
      end else begin
         case (cfg.mode)
            pss_pkg::MODE_RAW: kind_in = pss_pkg::KIND_RAW;
            pss_pkg::MODE_LINEAR: begin
               kind_in  = (cfg.max_raw == '0) ? pss_pkg::KIND_ZERO : pss_pkg::KIND_LIN;
               mul_a_in = cfg.inverse ? (cfg.max_raw - raw_ff) : raw_ff;
            end
            pss_pkg::MODE_SYM, pss_pkg::MODE_SYM_DB: begin
               if (above) begin
                  kind_in  = pss_pkg::KIND_HI;
                  mul_a_in = raw_ff - upper[RW-1:0];
                  div_d_in = cfg.max_raw - upper[RW-1:0];
               end else if (below) begin
                  kind_in  = pss_pkg::KIND_LO;
                  div_d_in = lower[RW-1:0];
               end else begin
                  kind_in  = pss_pkg::KIND_ZERO;
               end
            end
            pss_pkg::MODE_CONT: begin
               if (cfg.sector_width != '0) begin
                  kind_in  = pss_pkg::KIND_SECTOR;
                  div_d_in = cfg.sector_width;
               end
            end
            default: kind_in = pss_pkg::KIND_ZERO;
         endcase
      end
   end

   assign rem_sh = {rem_ff[MW-2:0], quo_ff[PW-1]};
   assign ge     = rem_sh >= {1'b0, div_d_ff};

   // work out the new held value and sector
   always_comb begin
      quo_s   = 17'($signed({1'b0, quo_ff[pss_pkg::LIMIT_W-1:0]}));
      lim_s   = 17'($signed({1'b0, cfg.full_scale}));
      v_sym   = (kind_ff == pss_pkg::KIND_LO) ? (quo_s - lim_s) : quo_s;
      sym_out = cfg.inverse ? HW'(-v_sym) : HW'(v_sym);

      sector  = quo_ff[RW-1:0];
      at_edge = ({1'b0, rem_ff[RW-1:0]} < (RW+1)'(cfg.sector_hysteresis)) ||
                ($signed({2'b0, rem_ff[RW-1:0]}) >=
                 ($signed({2'b0, div_d_ff}) - $signed(14'(cfg.sector_hysteresis))));
      half_s  = 17'($signed({1'b0, cfg.sector_count >> 1}));
      count_s = 17'($signed({1'b0, cfg.sector_count}));
      delta   = 17'($signed({1'b0, sector})) - 17'($signed({1'b0, last_ff}));
      // take the shorter way round the revolution
      if (delta > half_s) begin
         delta = delta - count_s;
      end else if (delta < -half_s) begin
         delta = delta + count_s;
      end
      v_cont  = cfg.inverse ? (17'(held_ff) - delta) : (17'(held_ff) + delta);
      overrun = (v_cont > lim_s) || (v_cont < -lim_s);

      held_in = held_ff;
      last_in = last_ff;
      case (kind_ff)
         pss_pkg::KIND_ZERO: held_in = '0;
         pss_pkg::KIND_RAW:  held_in = HW'({1'b0, raw_ff});
         pss_pkg::KIND_LIN:  held_in = HW'({1'b0, quo_ff[pss_pkg::LIMIT_W-1:0]});
         pss_pkg::KIND_HI,
         pss_pkg::KIND_LO:   held_in = sym_out;
         pss_pkg::KIND_SECTOR: begin
            if (!at_edge) begin
               held_in = overrun ? '0 : HW'(v_cont);
               last_in = sector;
            end
         end
         pss_pkg::KIND_PRIME: last_in = sector;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         raw_ff <= raw_in;
      end
      if (cmd.prep) begin
         kind_ff  <= kind_in;
         mul_a_ff <= mul_a_in;
         div_d_ff <= div_d_in;
      end
      if (cmd.mul) begin
         rem_ff <= '0;
         if (kind_ff == pss_pkg::KIND_SECTOR || kind_ff == pss_pkg::KIND_PRIME) begin
            quo_ff <= PW'(raw_ff);
         end else begin
            quo_ff <= mul_a_ff * cfg.full_scale;
         end
      end else if (cmd.step) begin
         rem_ff <= ge ? (rem_sh - {1'b0, div_d_ff}) : rem_sh;
         quo_ff <= {quo_ff[PW-2:0], ge};
      end
      if (cmd.commit) begin
         value_ff <= held_in[pss_pkg::VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         last_ff <= '0;
      end else if (cmd.commit) begin
         held_ff <= held_in;
         last_ff <= last_in;
      end
   end

endmodule

// ===== hdl/pot_sample_scaler.sv =====
// Top level of the potentiometer sample scaler.
// Scaling and sector modes pass through set-up, multiply, 26 steps of the
// shift-subtract divider and commit; when no division is needed (raw, dead zone,
// hold) the divider steps are skipped. One request in flight at a time: a new
// request is taken only after the last result has been committed for output.
// Reset (synchronous) restores the register defaults and clears held value and sector.
module pot_sample_scaler #(
   parameter int ADC_BITS = pss_pkg::ADC_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   pss_req_if.sink    req_ch,
   pss_rsp_if.source  rsp_ch,
   pss_csr_if.sink    csr_ch
);

   pss_pkg::cfg_type       cfg;
   pss_pkg::ctrl_cmd_type  cmd;
   pss_pkg::dp_status_type status;

   pss_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .cfg       (cfg)
   );

   pss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pss_dp #(
      .ADC_BITS (ADC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_op     (req_ch.op),
      .req_sample (req_ch.sample),
      .rsp_value  (rsp_ch.value)
   );

endmodule

// ===== test/tb_pot_sample_scaler.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the potentiometer sample scaler: directed and random requests.
module tb_pot_sample_scaler;

   localparam int IDLE_LIMIT       = 4000;
   localparam int SETTLE_CYCLES    = 40;
   localparam int NUM_SETTINGS     = 20;
   localparam int REQS_PER_SETTING = 66;
   localparam int REPORT_LIMIT     = 10;
   localparam int SAMPLE_TOP       = (1 << pss_pkg::SAMPLE_W) - 1;
   localparam logic [2:0] MODE_SPARE     = 3'd6;
   localparam logic [2:0] MODE_LAST_CODE = 3'd7;
   localparam logic [pss_pkg::CSR_IDX_W-1:0] FIRST_SPARE_REG =
      pss_pkg::CSR_IDX_W'(pss_pkg::REG_SECTOR_COUNT + 1);

   // Predicts the held control value and keeps the values still owed by the block
   class control_value_board;
      logic [2:0] mode;
      bit         inverse;
      int         max_raw, full_scale, dead_band;
      int         sector_width, sector_hyst, sector_count;
      int         held_value, last_sector;
      logic signed [pss_pkg::VALUE_W-1:0] pending_values[$];
      int         value_errors;

      function new();
         mode          = pss_pkg::MODE_LINEAR;
         inverse       = 1'b0;
         max_raw       = 1023;
         full_scale    = 10000;
         dead_band     = 0;
         sector_width  = 64;
         sector_hyst   = 8;
         sector_count  = 16;
         held_value    = 0;
         last_sector   = 0;
         value_errors  = 0;
      endfunction

      function void set_reg(logic [pss_pkg::CSR_IDX_W-1:0] idx,
                            logic [pss_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            pss_pkg::REG_MODE:         mode         = data[2:0];
            pss_pkg::REG_INVERSE:      inverse      = data[0];
            pss_pkg::REG_MAX_RAW:      max_raw      = int'(data[pss_pkg::RAW_W-1:0]);
            pss_pkg::REG_FULL_SCALE:   full_scale   = int'(data[pss_pkg::LIMIT_W-1:0]);
            pss_pkg::REG_DEAD_BAND:    dead_band    = int'(data[pss_pkg::BAND_W-1:0]);
            pss_pkg::REG_SECTOR_WIDTH: sector_width = int'(data[pss_pkg::RAW_W-1:0]);
            pss_pkg::REG_SECTOR_HYST:  sector_hyst  = int'(data[pss_pkg::BAND_W-1:0]);
            pss_pkg::REG_SECTOR_COUNT: sector_count = int'(data[pss_pkg::COUNT_W-1:0]);
            default: ;
         endcase
      endfunction

      // Map rule with division truncating toward zero; an empty span yields out_lo
      static function int ratio_scale(int x, int in_lo, int in_hi, int out_lo, int out_hi);
         longint span, num;
         span = longint'(in_hi) - longint'(in_lo);
         if (span == 0)
            return out_lo;
         num = (longint'(x) - longint'(in_lo)) * (longint'(out_hi) - longint'(out_lo));
         return int'(num / span + longint'(out_lo));
      endfunction

      function void note_request(pss_pkg::op_type op, logic [pss_pkg::SAMPLE_W-1:0] smp);
         int r, center, upper, lower, v, pos, sect, delta, half;
         r = int'(smp) % (1 << pss_pkg::ADC_BITS_DEFAULT);
         if (r > max_raw)
            r = max_raw;
         center = (max_raw + 1) / 2;
         if (op == pss_pkg::OP_PRIME) begin
            if (mode == pss_pkg::MODE_CONT && sector_width != 0)
               last_sector = (r / sector_width) % (1 << pss_pkg::RAW_W);
         end else begin
            case (mode)
               pss_pkg::MODE_RAW: held_value = r;
               pss_pkg::MODE_LINEAR: begin
                  if (inverse)
                     held_value = ratio_scale(max_raw - r, 0, max_raw, 0, full_scale);
                  else
                     held_value = ratio_scale(r, 0, max_raw, 0, full_scale);
               end
               pss_pkg::MODE_SYM, pss_pkg::MODE_SYM_DB: begin
                  upper = center;
                  lower = center;
                  if (mode == pss_pkg::MODE_SYM_DB) begin
                     upper = center + dead_band;
                     lower = center - dead_band;
                  end
                  if (r > upper)
                     v = ratio_scale(r, upper, max_raw, 0, full_scale);
                  else if (r < lower)
                     v = ratio_scale(r, 0, lower, -full_scale, 0);
                  else
                     v = 0;
                  held_value = inverse ? -v : v;
               end
               pss_pkg::MODE_CONT: begin
                  // hold inside the hysteresis margins and when the width is zero
                  if (sector_width != 0) begin
                     pos = r % sector_width;
                     if (pos >= sector_hyst && pos < sector_width - sector_hyst) begin
                        sect  = r / sector_width;
                        delta = sect - last_sector;
                        half  = sector_count / 2;
                        if (delta > half)
                           delta -= sector_count;
                        else if (delta < -half)
                           delta += sector_count;
                        v = inverse ? held_value - delta : held_value + delta;
                        last_sector = sect % (1 << pss_pkg::RAW_W);
                        if (v > full_scale || v < -full_scale)
                           v = 0;
                        held_value = v;
                     end
                  end
               end
               default: held_value = 0;
            endcase
         end
         pending_values.push_back(pss_pkg::VALUE_W'(held_value));
      endfunction

      function void check_value(logic signed [pss_pkg::VALUE_W-1:0] got);
         logic signed [pss_pkg::VALUE_W-1:0] want;
         if (pending_values.size() == 0) begin
            value_errors++;
            if (value_errors <= REPORT_LIMIT)
               $display("unexpected result: value %0d", got);
         end else begin
            want = pending_values.pop_front();
            if (got !== want) begin
               value_errors++;
               if (value_errors <= REPORT_LIMIT)
                  $display("value mismatch: expected %0d, got %0d", want, got);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   gap_pct = 0;
   int   stall_pct = 0;
   int   idle_cycles = 0;
   control_value_board value_board;

   pss_req_if req_ch ();
   pss_rsp_if rsp_ch ();
   pss_csr_if csr_ch ();

   pot_sample_scaler u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #2 clock = ~clock;

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         value_board.check_value(rsp_ch.value);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_sample(input pss_pkg::op_type op,
                              input logic [pss_pkg::SAMPLE_W-1:0] smp);
      if ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_ch.valid  <= 1'b1;
      req_ch.op     <= op;
      req_ch.sample <= smp;
      do @(posedge clock); while (!req_ch.ready);
      value_board.note_request(op, smp);
   endtask

   task automatic wait_until_drained();
      if (req_ch.valid)
         req_ch.valid <= 1'b0;
      while (value_board.pending_values.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [pss_pkg::CSR_IDX_W-1:0] idx, input int unsigned val);
      int w;
      logic [pss_pkg::CSR_DATA_W-1:0] data;
      case (idx)
         pss_pkg::REG_MODE:                                 w = 3;
         pss_pkg::REG_INVERSE:                              w = 1;
         pss_pkg::REG_MAX_RAW, pss_pkg::REG_SECTOR_WIDTH:   w = pss_pkg::RAW_W;
         pss_pkg::REG_FULL_SCALE:                           w = pss_pkg::LIMIT_W;
         pss_pkg::REG_DEAD_BAND, pss_pkg::REG_SECTOR_HYST:  w = pss_pkg::BAND_W;
         default:                                           w = pss_pkg::COUNT_W;
      endcase
      // junk above the field width must be dropped by the register
      data = pss_pkg::CSR_DATA_W'(val | ($urandom << w));
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      value_board.set_reg(idx, data);
   endtask

   task automatic apply_setting(input logic [2:0] md, input bit inv, input int mx, input int lim,
                                input int band, input int width, input int hyst, input int cnt);
      wait_until_drained();
      write_reg(pss_pkg::CSR_IDX_W'($urandom_range(FIRST_SPARE_REG,
                                                   (1 << pss_pkg::CSR_IDX_W) - 1)), $urandom);
      write_reg(pss_pkg::REG_MODE, md);
      write_reg(pss_pkg::REG_INVERSE, inv);
      write_reg(pss_pkg::REG_MAX_RAW, mx);
      write_reg(pss_pkg::REG_FULL_SCALE, lim);
      write_reg(pss_pkg::REG_DEAD_BAND, band);
      write_reg(pss_pkg::REG_SECTOR_WIDTH, width);
      write_reg(pss_pkg::REG_SECTOR_HYST, hyst);
      write_reg(pss_pkg::REG_SECTOR_COUNT, cnt);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int mx, lim, band, width, hyst, cnt, walk, step, pause_at, pick, centre;
      logic [2:0] md;
      pss_pkg::op_type op;
      logic [pss_pkg::SAMPLE_W-1:0] smp;

      value_board = new();
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.op     <= pss_pkg::OP_UPDATE;
      req_ch.sample <= '0;
      csr_ch.valid  <= 1'b0;
      csr_ch.index  <= pss_pkg::REG_MODE;
      csr_ch.data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // register defaults after reset: linear, saturation above max_raw, prime ignored
      send_sample(pss_pkg::OP_UPDATE, 0);
      send_sample(pss_pkg::OP_UPDATE, 1023);
      send_sample(pss_pkg::OP_UPDATE, pss_pkg::SAMPLE_W'(SAMPLE_TOP));
      send_sample(pss_pkg::OP_UPDATE, 511);
      send_sample(pss_pkg::OP_PRIME, 300);

      apply_setting(pss_pkg::MODE_RAW, 1'b1, SAMPLE_TOP, 10000, 0, 64, 8, 16);
      send_sample(pss_pkg::OP_UPDATE, pss_pkg::SAMPLE_W'(SAMPLE_TOP));
      send_sample(pss_pkg::OP_UPDATE, 12'hAAA);
      send_sample(pss_pkg::OP_UPDATE, 12'h555);
      send_sample(pss_pkg::OP_PRIME, 0);

      apply_setting(pss_pkg::MODE_SYM, 1'b1, 1023, 16383, 0, 64, 8, 16);
      send_sample(pss_pkg::OP_UPDATE, 0);
      send_sample(pss_pkg::OP_UPDATE, 512);
      send_sample(pss_pkg::OP_UPDATE, 1023);

      apply_setting(pss_pkg::MODE_SYM_DB, 1'b0, 1023, 16383, 100, 64, 8, 16);
      send_sample(pss_pkg::OP_UPDATE, 560);
      send_sample(pss_pkg::OP_UPDATE, 1000);
      send_sample(pss_pkg::OP_UPDATE, 20);

      // sector counting: step up, edge hold, wrap the short way, overrun to zero
      apply_setting(pss_pkg::MODE_CONT, 1'b0, 1023, 3, 0, 64, 8, 16);
      send_sample(pss_pkg::OP_PRIME, 100);
      send_sample(pss_pkg::OP_UPDATE, 224);
      send_sample(pss_pkg::OP_UPDATE, 66);
      send_sample(pss_pkg::OP_UPDATE, 990);
      send_sample(pss_pkg::OP_UPDATE, 650);

      apply_setting(pss_pkg::MODE_CONT, 1'b1, 1023, 100, 0, 0, 8, 16);
      send_sample(pss_pkg::OP_PRIME, 500);
      send_sample(pss_pkg::OP_UPDATE, 500);

      apply_setting(MODE_SPARE, 1'b0, 1023, 100, 0, 64, 8, 16);
      send_sample(pss_pkg::OP_UPDATE, 100);

      // empty scaling span
      apply_setting(pss_pkg::MODE_LINEAR, 1'b0, 0, 16383, 0, 64, 8, 16);
      send_sample(pss_pkg::OP_UPDATE, pss_pkg::SAMPLE_W'(SAMPLE_TOP));

      for (int k = 0; k < NUM_SETTINGS; k++) begin
         pick = $urandom_range(99);
         if (pick < 10)
            md = pss_pkg::MODE_RAW;
         else if (pick < 25)
            md = pss_pkg::MODE_LINEAR;
         else if (pick < 40)
            md = pss_pkg::MODE_SYM;
         else if (pick < 55)
            md = pss_pkg::MODE_SYM_DB;
         else if (pick < 94)
            md = pss_pkg::MODE_CONT;
         else
            md = 3'($urandom_range(pss_pkg::MODE_CONT + 1, MODE_LAST_CODE));

         if (k == 0) begin
            mx = SAMPLE_TOP; lim = 16383; band = 2047; width = SAMPLE_TOP; hyst = 2047;
            cnt = 4096;
         end else if (k == 1) begin
            mx = 1; lim = 1; band = 0; width = 1; hyst = 0; cnt = 1;
         end else begin
            case ($urandom_range(3))
               0:       mx = SAMPLE_TOP;
               1:       mx = 1023;
               2:       mx = $urandom_range(0, 16);
               default: mx = $urandom_range(1, SAMPLE_TOP);
            endcase
            case ($urandom_range(2))
               0:       lim = 16383;
               1:       lim = $urandom_range(0, 40);
               default: lim = $urandom_range(1, 16383);
            endcase
            case ($urandom_range(2))
               0:       band = 0;
               1:       band = 2047;
               default: band = $urandom_range(0, mx / 2);
            endcase
            case ($urandom_range(9))
               0:             width = 0;
               1:             width = SAMPLE_TOP;
               2, 3, 4, 5, 6: width = $urandom_range(1, 64);
               default:       width = $urandom_range(1, SAMPLE_TOP);
            endcase
            case ($urandom_range(5))
               0:       hyst = 0;
               1:       hyst = 2047;
               default: hyst = $urandom_range(0, width / 3);
            endcase
            if ($urandom_range(3) != 0 && width != 0)
               cnt = (mx + width) / width;
            else
               cnt = $urandom_range(0, 4096);
         end
         apply_setting(md, 1'($urandom_range(1)), mx, lim, band, width, hyst, cnt);

         case (k % 4)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 61; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 61; end
            default: begin gap_pct = 32; stall_pct = 32; end
         endcase

         pause_at = $urandom_range(REQS_PER_SETTING - 1);
         walk = $urandom_range(mx);
         centre = (mx + 1) / 2;
         for (int n = 0; n < REQS_PER_SETTING; n++) begin
            // hold the sender until the block has answered everything
            if (n == pause_at)
               wait_until_drained();
            op = ($urandom_range(99) < 10) ? pss_pkg::OP_PRIME : pss_pkg::OP_UPDATE;
            if (md == pss_pkg::MODE_CONT && $urandom_range(3) != 0) begin
               // advance the knob a little at a time so sectors accumulate
               step = int'($urandom_range(2 * width + 2)) - width - 1;
               walk = walk + step;
               if (walk < 0)
                  walk = 0;
               if (walk > mx)
                  walk = mx;
               smp = pss_pkg::SAMPLE_W'(walk);
            end else begin
               case ($urandom_range(3))
                  0, 1: smp = pss_pkg::SAMPLE_W'($urandom_range(SAMPLE_TOP));
                  2:    smp = pss_pkg::SAMPLE_W'($urandom_range(mx));
                  default: begin
                     pick = centre + int'($urandom_range(2 * band + 4)) - band - 2;
                     if (pick < 0)
                        pick = 0;
                     if (pick > SAMPLE_TOP)
                        pick = SAMPLE_TOP;
                     smp = pss_pkg::SAMPLE_W'(pick);
                  end
               endcase
            end
            send_sample(op, smp);
         end
      end

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (value_board.value_errors == 0 && value_board.pending_values.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
